/* design/abc_pkg.sv */
// shared types and constants for the autoconfig board chain
`timescale 1ns / 1ps
package abc_pkg;
	localparam int MaxBoards = 16;
	localparam int ConfigBytes = 128;
	localparam int SlotIds = 16;
	localparam int IdxW = $clog2(MaxBoards);
	localparam int CntW = $clog2(MaxBoards + 1);
	localparam int ByteW = $clog2(ConfigBytes);
	localparam int LenW = $clog2(ConfigBytes + 1);
	localparam int StoreDepth = SlotIds * ConfigBytes;
	localparam int StoreAw = $clog2(StoreDepth);
	localparam logic [23:0] CfgWinLo = 24'hE80000;
	localparam logic [23:0] CfgWinHi = 24'hE8FFFF;
	localparam logic [7:0] ByteNone = 8'hFF;

	localparam logic [2:0] ReqCfgRead = 3'd0;
	localparam logic [2:0] ReqCfgWrite = 3'd1;
	localparam logic [2:0] ReqLookup = 3'd2;
	localparam logic [2:0] ReqRegister = 3'd3;
	localparam logic [2:0] ReqLoad = 3'd4;
	localparam logic [2:0] ReqRemove = 3'd5;
	localparam logic [2:0] ReqRestart = 3'd6;
	localparam logic [2:0] ReqNop = 3'd7;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StNoSlot = 2'd1;
	localparam logic [1:0] StFull = 2'd2;

	localparam logic RegBaseOff = 1'b0;
	localparam logic RegShutOff = 1'b1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [23:0] addr;
		logic [7:0] data;
		logic [3:0] slot;
		logic [2:0] size_code;
		logic [7:0] config_length;
		logic [6:0] byte_index;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic window_hit;
		logic [3:0] hit_slot;
		logic [22:0] window_offset;
		logic [1:0] status;
		logic pending_valid;
		logic [3:0] pending_slot;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic exec;      // latch request and apply updates that need no shift steps
		logic shift;     // move entry shift_idx+1 down to shift_idx
		logic drop_last; // clear last entry and decrement count
		logic finish;    // build response
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic remove_hit;
		logic [IdxW-1:0] remove_idx;
		logic [CntW-1:0] count;
	} sts_t;
endpackage

/* design/abc_ram.sv */
// generic ram with one write port, one read port and registered read
`timescale 1ns / 1ps
module abc_ram #(
	parameter int Width = 8,
	parameter int Depth = 2048
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* design/abc_ctrl.sv */
// request sequencer: accept, execute, compaction steps, response
`timescale 1ns / 1ps
module abc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] in_type,
	output logic out_valid,
	input logic out_ready,
	output abc_pkg::cmd_t cmd,
	output logic [abc_pkg::IdxW-1:0] shift_idx,
	input abc_pkg::sts_t sts
);
	typedef enum logic [1:0] {IDLE, EXEC, SHIFT, RESP} state_t;
	state_t state_q;
	logic [abc_pkg::IdxW-1:0] idx_q;
	logic [2:0] type_q;

	assign in_ready = (state_q == IDLE);
	assign out_valid = (state_q == RESP);
	assign shift_idx = idx_q;

	logic last_shift;
	assign last_shift = ({1'b0, idx_q} + 1'b1) >= sts.count;

	always_comb begin
		cmd = '0;
		cmd.exec = (state_q == IDLE) && in_valid;
		case (state_q)
			EXEC: cmd.finish = !(type_q == abc_pkg::ReqRemove && sts.remove_hit);
			SHIFT: begin
				if (last_shift) begin
					cmd.drop_last = 1'b1;
					cmd.finish = 1'b1;
				end else cmd.shift = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			idx_q <= '0;
			type_q <= '0;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					type_q <= in_type;
					state_q <= EXEC;
				end
				EXEC: begin
					if (type_q == abc_pkg::ReqRemove && sts.remove_hit) begin
						idx_q <= sts.remove_idx;
						state_q <= SHIFT;
					end else state_q <= RESP;
				end
				SHIFT: begin
					if (last_shift) state_q <= RESP;
					else idx_q <= idx_q + 1'b1;
				end
				RESP: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == EXEC || $past(state_q) == SHIFT)
		else $error("response without execution");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("accept while response pending");
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SHIFT |-> {1'b0, idx_q} < sts.count)
		else $error("shift index beyond table");
`endif
endmodule

/* design/abc_dp.sv */
// slot table, config store and response datapath
`timescale 1ns / 1ps
module abc_dp (
	input logic clk,
	input logic arst_n,
	input abc_pkg::cmd_t cmd,
	input logic [abc_pkg::IdxW-1:0] shift_idx,
	output abc_pkg::sts_t sts,
	input abc_pkg::req_t req,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [15:0] cfg_data,
	output abc_pkg::rsp_t rsp
);
	localparam int N = abc_pkg::MaxBoards;
	localparam int IW = abc_pkg::IdxW;
	localparam int CW = abc_pkg::CntW;

	logic [15:0] base_off_q, shut_off_q;
	logic [CW-1:0] count_q;
	logic [N-1:0] en_q, conf_q, shut_q;
	logic [7:0] base_q [N];
	logic [2:0] size_q [N];
	logic [abc_pkg::LenW-1:0] len_q [N];
	logic [3:0] num_q [N];
	logic [1:0] status_q;
	logic rd_ok_q, hit_q;
	logic [3:0] hit_slot_q;
	logic [22:0] woff_q;
	abc_pkg::rsp_t rsp_q;
	logic found_q;
	logic [IW-1:0] found_i_q;

	// pending: lowest live entry awaiting configuration
	logic pend_v;
	logic [IW-1:0] pend_i;
	always_comb begin
		pend_v = 1'b0;
		pend_i = '0;
		for (int i = N - 1; i >= 0; i--)
			if (CW'(i) < count_q && en_q[i] && !conf_q[i] && !shut_q[i]) begin
				pend_v = 1'b1;
				pend_i = IW'(i);
			end
	end

	// slot search
	logic found;
	logic [IW-1:0] found_i;
	always_comb begin
		found = 1'b0;
		found_i = '0;
		for (int i = N - 1; i >= 0; i--)
			if (CW'(i) < count_q && num_q[i] == req.slot) begin
				found = 1'b1;
				found_i = IW'(i);
			end
	end
	assign sts.remove_hit = found_q;
	assign sts.remove_idx = found_i_q;
	assign sts.count = count_q;

	// window match per entry
	logic [N-1:0] win_m;
	always_comb begin
		for (int i = 0; i < N; i++) begin
			logic [24:0] top;
			top = {1'b0, base_q[i], 16'h0} + (25'h10000 << size_q[i]);
			win_m[i] = CW'(i) < count_q && en_q[i] && conf_q[i] && base_q[i] != 8'h0
				&& req.addr[23:16] >= base_q[i] && {1'b0, req.addr} < top;
		end
	end
	logic w_hit;
	logic [IW-1:0] w_i;
	always_comb begin
		w_hit = 1'b0;
		w_i = '0;
		for (int i = N - 1; i >= 0; i--)
			if (win_m[i]) begin
				w_hit = 1'b1;
				w_i = IW'(i);
			end
	end

	logic in_cfg;
	logic [15:0] off;
	assign in_cfg = req.addr >= abc_pkg::CfgWinLo && req.addr <= abc_pkg::CfgWinHi;
	assign off = req.addr[15:0];

	// config store
	logic st_we;
	logic [abc_pkg::StoreAw-1:0] st_wa, st_ra;
	logic [7:0] st_rd;
	assign st_we = cmd.exec && req.req_type == abc_pkg::ReqLoad;
	assign st_wa = {req.slot, req.byte_index[abc_pkg::ByteW-1:0]};
	assign st_ra = {num_q[pend_i], off[abc_pkg::ByteW-1:0]};
	abc_ram #(.Width(8), .Depth(abc_pkg::StoreDepth)) u_store (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(req.data),
		.raddr(st_ra), .rdata(st_rd)
	);

	logic [abc_pkg::LenW-1:0] reg_len;
	assign reg_len = (req.config_length > 8'(abc_pkg::ConfigBytes))
		? abc_pkg::LenW'(abc_pkg::ConfigBytes) : abc_pkg::LenW'(req.config_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_off_q <= 16'd72;
			shut_off_q <= 16'd76;
			count_q <= '0;
			en_q <= '0;
			conf_q <= '0;
			shut_q <= '0;
			for (int i = 0; i < N; i++) begin
				base_q[i] <= '0;
				size_q[i] <= '0;
				len_q[i] <= '0;
				num_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == abc_pkg::RegBaseOff) base_off_q <= cfg_data;
				else shut_off_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (req.req_type)
					abc_pkg::ReqCfgWrite: if (in_cfg && pend_v) begin
						if (off == base_off_q) begin
							base_q[pend_i] <= req.data;
							conf_q[pend_i] <= 1'b1;
						end else if (off == shut_off_q) shut_q[pend_i] <= 1'b1;
					end
					abc_pkg::ReqRegister: if (req.config_length != 8'd0
						&& (found || count_q < CW'(N))) begin
						if (!found) count_q <= count_q + 1'b1;
						en_q[found ? found_i : IW'(count_q)] <= 1'b1;
						conf_q[found ? found_i : IW'(count_q)] <= 1'b0;
						shut_q[found ? found_i : IW'(count_q)] <= 1'b0;
						base_q[found ? found_i : IW'(count_q)] <= '0;
						size_q[found ? found_i : IW'(count_q)] <= req.size_code;
						len_q[found ? found_i : IW'(count_q)] <= reg_len;
						num_q[found ? found_i : IW'(count_q)] <= req.slot;
					end
					abc_pkg::ReqRestart: begin
						conf_q <= '0;
						shut_q <= '0;
						for (int i = 0; i < N; i++) base_q[i] <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.shift) begin
				en_q[shift_idx] <= en_q[shift_idx + 1'b1];
				conf_q[shift_idx] <= conf_q[shift_idx + 1'b1];
				shut_q[shift_idx] <= shut_q[shift_idx + 1'b1];
				base_q[shift_idx] <= base_q[shift_idx + 1'b1];
				size_q[shift_idx] <= size_q[shift_idx + 1'b1];
				len_q[shift_idx] <= len_q[shift_idx + 1'b1];
				num_q[shift_idx] <= num_q[shift_idx + 1'b1];
			end
			if (cmd.drop_last) begin
				en_q[IW'(count_q - 1'b1)] <= 1'b0;
				conf_q[IW'(count_q - 1'b1)] <= 1'b0;
				shut_q[IW'(count_q - 1'b1)] <= 1'b0;
				base_q[IW'(count_q - 1'b1)] <= '0;
				size_q[IW'(count_q - 1'b1)] <= '0;
				len_q[IW'(count_q - 1'b1)] <= '0;
				num_q[IW'(count_q - 1'b1)] <= '0;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// per-request results captured at execute
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			found_q <= found;
			found_i_q <= found_i;
			rd_ok_q <= req.req_type == abc_pkg::ReqCfgRead && in_cfg && pend_v
				&& {1'b0, off} < {{(17 - abc_pkg::LenW){1'b0}}, len_q[pend_i]};
			hit_q <= req.req_type == abc_pkg::ReqLookup && w_hit;
			hit_slot_q <= num_q[w_i];
			woff_q <= 23'(req.addr - {base_q[w_i], 16'h0});
			case (req.req_type)
				abc_pkg::ReqRegister: status_q <= (req.config_length == 8'd0)
					? abc_pkg::StNoSlot
					: (!found && count_q >= CW'(N)) ? abc_pkg::StFull : abc_pkg::StOk;
				abc_pkg::ReqRemove: status_q <= found ? abc_pkg::StOk : abc_pkg::StNoSlot;
				default: status_q <= abc_pkg::StOk;
			endcase
		end
		if (cmd.finish) begin
			rsp_q.read_data <= rd_ok_q ? st_rd : abc_pkg::ByteNone;
			rsp_q.window_hit <= hit_q;
			rsp_q.hit_slot <= hit_q ? hit_slot_q : 4'd0;
			rsp_q.window_offset <= hit_q ? woff_q : 23'd0;
			rsp_q.status <= status_q;
		end
	end

	// pending is read from the settled table while the response is held
	logic [IW-1:0] pend_fix;
	logic pend_vfix;
	always_comb begin
		pend_vfix = pend_v;
		pend_fix = pend_i;
	end
	assign rsp.read_data = rsp_q.read_data;
	assign rsp.window_hit = rsp_q.window_hit;
	assign rsp.hit_slot = rsp_q.hit_slot;
	assign rsp.window_offset = rsp_q.window_offset;
	assign rsp.status = rsp_q.status;
	assign rsp.pending_valid = pend_vfix;
	assign rsp.pending_slot = pend_vfix ? num_q[pend_fix] : 4'd0;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N)) else $error("board count overflow");
	a_drop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop_last |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not shrink table");
	a_hit_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && hit_q |=> rsp.window_hit) else $error("lost window hit");
`endif
endmodule

/* design/autoconfig_board_chain.sv */
// top level: stream ports, config write port, controller and datapath
//  channel | dir | signals                         | payload
//  s_axis  | in  | s_axis_tvalid/tready/tdata      | request fields
//  m_axis  | out | m_axis_tvalid/tready/tdata      | result fields
//  cfg     | in  | cfg_valid/ready, cfg_index/data | offset registers
// a request passes through accept, execute and respond; a remove that finds
// its slot also moves each table entry above the removed one down (table
// shift) and then clears the last entry.
// arst_n clears the table; the config store is not cleared.
// a new request is taken only after the response has been taken.
`timescale 1ns / 1ps
module autoconfig_board_chain (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// req_type[2:0] addr[26:3] data[34:27] slot[38:35] size_code[41:39]
	// config_length[49:42] byte_index[56:50]
	input logic [63:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// read_data[7:0] window_hit[8] hit_slot[12:9] window_offset[35:13]
	// status[37:36] pending_valid[38] pending_slot[42:39]
	output logic [47:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);
	abc_pkg::req_t req;
	abc_pkg::rsp_t rsp;
	abc_pkg::cmd_t cmd;
	abc_pkg::sts_t sts;
	logic [abc_pkg::IdxW-1:0] shift_idx;

	assign req.req_type = s_axis_tdata[2:0];
	assign req.addr = s_axis_tdata[26:3];
	assign req.data = s_axis_tdata[34:27];
	assign req.slot = s_axis_tdata[38:35];
	assign req.size_code = s_axis_tdata[41:39];
	assign req.config_length = s_axis_tdata[49:42];
	assign req.byte_index = s_axis_tdata[56:50];
	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {5'd0, rsp.pending_slot, rsp.pending_valid, rsp.status,
		rsp.window_offset, rsp.hit_slot, rsp.window_hit, rsp.read_data};

	abc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_type(req.req_type), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .shift_idx(shift_idx), .sts(sts)
	);
	abc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .shift_idx(shift_idx), .sts(sts),
		.req(req), .cfg_we(cfg_valid), .cfg_idx(cfg_index[0]), .cfg_data(cfg_data),
		.rsp(rsp)
	);
endmodule

/* tb/testbench.sv */
// self-checking testbench for the autoconfig board chain
`timescale 1ns / 1ps
module testbench;
	localparam int WatchLimit = 4000;
	localparam int DirRows = 27;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	autoconfig_board_chain uut (.*);

	always #5 clk = ~clk;

	// board table as the block should hold it
	int brd_count;
	logic brd_en [abc_pkg::MaxBoards];
	logic brd_cfgd [abc_pkg::MaxBoards];
	logic brd_shut [abc_pkg::MaxBoards];
	logic [7:0] brd_base [abc_pkg::MaxBoards];
	logic [2:0] brd_size [abc_pkg::MaxBoards];
	int brd_len [abc_pkg::MaxBoards];
	logic [3:0] brd_num [abc_pkg::MaxBoards];
	logic [7:0] rom_bytes [abc_pkg::SlotIds][abc_pkg::ConfigBytes];
	bit rom_loaded [abc_pkg::SlotIds][abc_pkg::ConfigBytes];
	bit pend_ok;
	int pend_idx;
	logic [15:0] base_off_reg = 16'd72;
	logic [15:0] shut_off_reg = 16'd76;

	abc_pkg::rsp_t pending_rsp [$];
	int mismatches = 0;
	int watch_cnt = 0;
	int stall_pct = 0;
	int idle_pct = 0;

	abc_pkg::req_t dir_req [DirRows];
	abc_pkg::rsp_t dir_rsp [DirRows];
	bit dir_has [DirRows];

	function automatic void find_pending();
		pend_ok = 1'b0;
		pend_idx = 0;
		for (int i = 0; i < brd_count; i++) begin
			if (brd_en[i] && !brd_cfgd[i] && !brd_shut[i]) begin
				pend_ok = 1'b1;
				pend_idx = i;
				return;
			end
		end
	endfunction

	function automatic int entry_of(logic [3:0] num);
		for (int i = 0; i < brd_count; i++)
			if (brd_num[i] == num)
				return i;
		return -1;
	endfunction

	function automatic void wipe_entry(int i);
		brd_en[i] = 0;
		brd_cfgd[i] = 0;
		brd_shut[i] = 0;
		brd_base[i] = '0;
		brd_size[i] = '0;
		brd_len[i] = 0;
		brd_num[i] = '0;
	endfunction

	// applies one request to the board table and returns the response
	function automatic abc_pkg::rsp_t apply_request(abc_pkg::req_t r);
		abc_pkg::rsp_t o;
		bit in_win;
		logic [15:0] off;
		logic [31:0] base, size;
		int e, len;
		o = '0;
		o.read_data = abc_pkg::ByteNone;
		in_win = (r.addr >= abc_pkg::CfgWinLo) && (r.addr <= abc_pkg::CfgWinHi);
		off = r.addr[15:0];
		case (r.req_type)
			abc_pkg::ReqCfgRead: begin
				if (in_win && pend_ok && off < brd_len[pend_idx])
					o.read_data = rom_bytes[brd_num[pend_idx]][off];
			end
			abc_pkg::ReqCfgWrite: begin
				if (in_win && pend_ok) begin
					if (off == base_off_reg) begin
						brd_base[pend_idx] = r.data;
						brd_cfgd[pend_idx] = 1;
						find_pending();
					end else if (off == shut_off_reg) begin
						brd_shut[pend_idx] = 1;
						find_pending();
					end
				end
			end
			abc_pkg::ReqLookup: begin
				for (int i = 0; i < brd_count; i++) begin
					base = {8'd0, brd_base[i], 16'd0};
					size = 32'h10000 << brd_size[i];
					if (brd_en[i] && brd_cfgd[i] && base != 0 &&
							{8'd0, r.addr} >= base && {8'd0, r.addr} < base + size) begin
						o.window_hit = 1'b1;
						o.hit_slot = brd_num[i];
						o.window_offset = 23'({8'd0, r.addr} - base);
						break;
					end
				end
			end
			abc_pkg::ReqRegister: begin
				len = r.config_length;
				if (len == 0) begin
					o.status = abc_pkg::StNoSlot;
				end else begin
					if (len > abc_pkg::ConfigBytes)
						len = abc_pkg::ConfigBytes;
					e = entry_of(r.slot);
					if (e < 0 && brd_count >= abc_pkg::MaxBoards) begin
						o.status = abc_pkg::StFull;
					end else begin
						if (e < 0) begin
							e = brd_count;
							brd_count++;
						end
						wipe_entry(e);
						brd_en[e] = 1;
						brd_size[e] = r.size_code;
						brd_len[e] = len;
						brd_num[e] = r.slot;
						find_pending();
					end
				end
			end
			abc_pkg::ReqLoad: begin
				rom_bytes[r.slot][r.byte_index] = r.data;
				rom_loaded[r.slot][r.byte_index] = 1;
			end
			abc_pkg::ReqRemove: begin
				e = entry_of(r.slot);
				if (e < 0) begin
					o.status = abc_pkg::StNoSlot;
				end else begin
					for (int i = e + 1; i < brd_count; i++) begin
						brd_en[i-1] = brd_en[i];
						brd_cfgd[i-1] = brd_cfgd[i];
						brd_shut[i-1] = brd_shut[i];
						brd_base[i-1] = brd_base[i];
						brd_size[i-1] = brd_size[i];
						brd_len[i-1] = brd_len[i];
						brd_num[i-1] = brd_num[i];
					end
					wipe_entry(brd_count - 1);
					brd_count--;
					find_pending();
				end
			end
			abc_pkg::ReqRestart: begin
				for (int i = 0; i < brd_count; i++) begin
					brd_cfgd[i] = 0;
					brd_shut[i] = 0;
					brd_base[i] = '0;
				end
				find_pending();
			end
			default: ;
		endcase
		o.pending_valid = pend_ok;
		o.pending_slot = pend_ok ? brd_num[pend_idx] : 4'd0;
		return o;
	endfunction

	function automatic abc_pkg::req_t mk_req(logic [2:0] t, logic [23:0] a, logic [7:0] d,
			logic [3:0] s, logic [2:0] z, logic [7:0] l, logic [6:0] b);
		abc_pkg::req_t r;
		r.req_type = t;
		r.addr = a;
		r.data = d;
		r.slot = s;
		r.size_code = z;
		r.config_length = l;
		r.byte_index = b;
		return r;
	endfunction

	// mostly well-formed bus traffic, fields not used by the request left random
	function automatic abc_pkg::req_t random_request();
		abc_pkg::req_t r;
		logic [63:0] raw;
		int pick, i;
		logic [31:0] base, size;
		raw = {$urandom, $urandom};
		r = raw[$bits(abc_pkg::req_t)-1:0];
		pick = $urandom_range(99);
		if (pick < 15) begin
			// noise, any request code with random fields
		end else if (pick < 23) begin
			r.req_type = abc_pkg::ReqRegister;
			if ($urandom_range(9) != 0)
				r.config_length = 8'($urandom_range(1, 16));
		end else if (pick < 43) begin
			r.req_type = abc_pkg::ReqLoad;
			if (brd_count > 0 && $urandom_range(3) != 0)
				r.slot = brd_num[$urandom_range(brd_count - 1)];
			if ($urandom_range(3) != 0)
				r.byte_index = 7'($urandom_range(15));
		end else if (pick < 63) begin
			r.req_type = abc_pkg::ReqCfgRead;
			if ($urandom_range(9) != 0)
				r.addr = abc_pkg::CfgWinLo | 24'($urandom_range(20));
		end else if (pick < 80) begin
			r.req_type = abc_pkg::ReqCfgWrite;
			case ($urandom_range(9))
				0: ;
				1, 2, 3, 4, 5: r.addr = abc_pkg::CfgWinLo | {8'd0, base_off_reg};
				6, 7, 8: r.addr = abc_pkg::CfgWinLo | {8'd0, shut_off_reg};
				default: r.addr = abc_pkg::CfgWinLo | 24'($urandom_range(65535));
			endcase
		end else if (pick < 93) begin
			r.req_type = abc_pkg::ReqLookup;
			if (brd_count > 0 && $urandom_range(4) != 0) begin
				i = $urandom_range(brd_count - 1);
				base = {8'd0, brd_base[i], 16'd0};
				size = 32'h10000 << brd_size[i];
				r.addr = 24'(base + $urandom_range(size + 32'h100) - 32'h80);
			end
		end else if (pick < 97) begin
			r.req_type = abc_pkg::ReqRemove;
		end else begin
			r.req_type = abc_pkg::ReqRestart;
		end
		// never read a rom byte that was not loaded: load it instead
		if (r.req_type == abc_pkg::ReqCfgRead && r.addr >= abc_pkg::CfgWinLo &&
				r.addr <= abc_pkg::CfgWinHi && pend_ok &&
				r.addr[15:0] < brd_len[pend_idx] &&
				!rom_loaded[brd_num[pend_idx]][r.addr[6:0]]) begin
			r.req_type = abc_pkg::ReqLoad;
			r.slot = brd_num[pend_idx];
			r.byte_index = r.addr[6:0];
		end
		return r;
	endfunction

	task automatic send_request(abc_pkg::req_t r, bit typed, abc_pkg::rsp_t want);
		abc_pkg::rsp_t got;
		got = apply_request(r);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		pending_rsp.push_back(typed ? want : got);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, r.byte_index, r.config_length, r.size_code, r.slot,
			r.data, r.addr, r.req_type};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == abc_pkg::RegBaseOff)
			base_off_reg = val;
		else
			shut_off_reg = val;
	endtask

	function automatic abc_pkg::rsp_t mk_rsp(logic [7:0] rd, logic [1:0] st);
		abc_pkg::rsp_t o;
		o = '0;
		o.read_data = rd;
		o.status = st;
		return o;
	endfunction

	task automatic fill_directed();
		dir_has = '{default: 0};
		dir_rsp = '{default: '0};
		dir_req[0] = mk_req(abc_pkg::ReqCfgRead, 24'hE80000, 8'h00, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_has[0] = 1;
		dir_rsp[0] = mk_rsp(abc_pkg::ByteNone, abc_pkg::StOk);
		dir_req[1] = mk_req(abc_pkg::ReqRemove, 24'h0, 8'h0, 4'd3, 3'd0, 8'd0, 7'd0);
		dir_has[1] = 1;
		dir_rsp[1] = mk_rsp(abc_pkg::ByteNone, abc_pkg::StNoSlot);
		dir_req[2] = mk_req(abc_pkg::ReqRegister, 24'h0, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_has[2] = 1;
		dir_rsp[2] = mk_rsp(abc_pkg::ByteNone, abc_pkg::StNoSlot);
		// length above the rom size saturates
		dir_req[3] = mk_req(abc_pkg::ReqRegister, 24'hFFFFFF, 8'hFF, 4'd15, 3'd7, 8'd255,
			7'd127);
		dir_req[4] = mk_req(abc_pkg::ReqRegister, 24'h0, 8'h0, 4'd0, 3'd0, 8'd1, 7'd0);
		dir_req[5] = mk_req(abc_pkg::ReqLoad, 24'h0, 8'hAA, 4'd15, 3'd0, 8'd0, 7'd0);
		dir_req[6] = mk_req(abc_pkg::ReqLoad, 24'h0, 8'h55, 4'd15, 3'd0, 8'd0, 7'd127);
		dir_req[7] = mk_req(abc_pkg::ReqLoad, 24'h0, 8'h00, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[8] = mk_req(abc_pkg::ReqCfgRead, 24'hE80000, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[9] = mk_req(abc_pkg::ReqCfgRead, 24'hE8007F, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[10] = mk_req(abc_pkg::ReqCfgRead, 24'hE80080, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[11] = mk_req(abc_pkg::ReqCfgRead, 24'hE7FFFF, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[12] = mk_req(abc_pkg::ReqCfgWrite, 24'hE80048, 8'hFF, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[13] = mk_req(abc_pkg::ReqCfgRead, 24'hE80000, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[14] = mk_req(abc_pkg::ReqCfgRead, 24'hE80001, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[15] = mk_req(abc_pkg::ReqCfgWrite, 24'hE8004C, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		// nothing pending, write dropped
		dir_req[16] = mk_req(abc_pkg::ReqCfgWrite, 24'hE80048, 8'h12, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[17] = mk_req(abc_pkg::ReqLookup, 24'hFF0000, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[18] = mk_req(abc_pkg::ReqLookup, 24'hFFFFFF, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[19] = mk_req(abc_pkg::ReqLookup, 24'h000000, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[20] = mk_req(abc_pkg::ReqNop, 24'hFFFFFF, 8'hFF, 4'd15, 3'd7, 8'd255, 7'd127);
		dir_req[21] = mk_req(abc_pkg::ReqRegister, 24'h0, 8'h0, 4'd2, 3'd3, 8'd2, 7'd0);
		// zero base never hits
		dir_req[22] = mk_req(abc_pkg::ReqCfgWrite, 24'hE80048, 8'h00, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[23] = mk_req(abc_pkg::ReqLookup, 24'h000010, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
		dir_req[24] = mk_req(abc_pkg::ReqRegister, 24'h0, 8'h0, 4'd0, 3'd1, 8'd4, 7'd0);
		dir_req[25] = mk_req(abc_pkg::ReqRemove, 24'h0, 8'h0, 4'd15, 3'd0, 8'd0, 7'd0);
		dir_req[26] = mk_req(abc_pkg::ReqRestart, 24'h0, 8'h0, 4'd0, 3'd0, 8'd0, 7'd0);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// response checker
	always @(posedge clk) begin
		abc_pkg::rsp_t act, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act.read_data = m_axis_tdata[7:0];
			act.window_hit = m_axis_tdata[8];
			act.hit_slot = m_axis_tdata[12:9];
			act.window_offset = m_axis_tdata[35:13];
			act.status = m_axis_tdata[37:36];
			act.pending_valid = m_axis_tdata[38];
			act.pending_slot = m_axis_tdata[42:39];
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %h", m_axis_tdata);
			end else begin
				exp_r = pending_rsp.pop_front();
				if (act.read_data !== exp_r.read_data || act.window_hit !== exp_r.window_hit ||
						act.hit_slot !== exp_r.hit_slot ||
						act.window_offset !== exp_r.window_offset ||
						act.status !== exp_r.status ||
						act.pending_valid !== exp_r.pending_valid ||
						act.pending_slot !== exp_r.pending_slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch rd %h/%h hit %b/%b slot %h/%h off %h/%h",
							" st %h/%h pv %b/%b ps %h/%h"},
							exp_r.read_data, act.read_data, exp_r.window_hit, act.window_hit,
							exp_r.hit_slot, act.hit_slot, exp_r.window_offset, act.window_offset,
							exp_r.status, act.status, exp_r.pending_valid, act.pending_valid,
							exp_r.pending_slot, act.pending_slot);
				end
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			watch_cnt <= 0;
		else
			watch_cnt <= watch_cnt + 1;
		if (watch_cnt >= WatchLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		brd_count = 0;
		for (int i = 0; i < abc_pkg::MaxBoards; i++)
			wipe_entry(i);
		rom_loaded = '{default: '{default: 0}};
		find_pending();
		fill_directed();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < DirRows; n++)
			send_request(dir_req[n], dir_has[n], dir_rsp[n]);
		for (int ph = 0; ph < 16; ph++) begin
			case (ph / 4)
				1: begin
					write_reg(abc_pkg::RegBaseOff, 16'd0);
					write_reg(abc_pkg::RegShutOff, 16'hFFFF);
				end
				// same offset for both, base write wins
				2: begin
					write_reg(abc_pkg::RegBaseOff, 16'd5);
					write_reg(abc_pkg::RegShutOff, 16'd5);
				end
				3: begin
					write_reg(abc_pkg::RegBaseOff, 16'($urandom_range(20)));
					write_reg(abc_pkg::RegShutOff, 16'($urandom_range(21, 40)));
				end
				default: ;
			endcase
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 87; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 87; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			for (int n = 0; n < 50; n++)
				send_request(random_request(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
